// ===== design/lorenz_pkg.sv =====
// Shared types and codes for the Lorenz Euler-step core.
// Used by lorenz_alu, the top level and the port checker.
package lorenz_pkg;

    typedef enum logic [1:0] {
        REQ_STEP    = 2'd0,
        REQ_BATCH   = 2'd1,
        REQ_LOAD    = 2'd2,
        REQ_RESTORE = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        REG_SIGMA  = 3'd0,
        REG_RHO    = 3'd1,
        REG_BETA   = 3'd2,
        REG_STEP_H = 3'd3,
        REG_WARMUP = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_COEF,
        ST_XY,
        ST_NEWX,
        ST_TY,
        ST_TZ,
        ST_NEWY,
        ST_NEWZ
    } state_t;

    localparam logic [15:0] WARMUP_INIT = 16'd100;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [6:0]         batch_count;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] load_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               coords_valid;
        logic [31:0]        step_number;
        logic               from_batch;
        logic [5:0]         batch_index;
        logic               last;
    } res_t;

    // Control for the shared arithmetic unit
    typedef struct packed {
        logic mul_en;
        logic sub;
    } alu_op_t;

endpackage

// ===== design/lorenz_alu.sv =====
// Shared arithmetic unit: one 32x32 signed multiplier with a registered product,
// fixed-point rescale with saturation, and one saturating adder/subtractor.
// Depends on lorenz_pkg.
module lorenz_alu #(
    parameter int FRAC_BITS = 22
) (
    input  logic               clk,
    input  lorenz_pkg::alu_op_t op,
    input  logic signed [31:0] mul_a,
    input  logic signed [31:0] mul_b,
    input  logic signed [31:0] add_a,
    input  logic signed [31:0] add_b,
    output logic signed [31:0] fm,
    output logic signed [31:0] sum
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic signed [63:0] shifted;
    logic signed [32:0] wide_sum;

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (op.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Arithmetic shift floors toward minus infinity
    assign shifted = prod_reg >>> FRAC_BITS;

    always_comb
    begin
        if (shifted[63:31] == {33{shifted[31]}})
        begin
            fm = shifted[31:0];
        end
        else if (shifted[63])
        begin
            fm = 32'sh8000_0000;
        end
        else
        begin
            fm = 32'sh7FFF_FFFF;
        end
    end

    always_comb
    begin
        if (op.sub)
        begin
            wide_sum = {add_a[31], add_a} - {add_b[31], add_b};
        end
        else
        begin
            wide_sum = {add_a[31], add_a} + {add_b[31], add_b};
        end
        if (wide_sum[32] != wide_sum[31])
        begin
            sum = wide_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum = wide_sum[31:0];
        end
    end

endmodule

// ===== design/lorenz_attractor_euler_step_core.sv =====
// Lorenz attractor generator, forward Euler steps in signed fixed point.
// Depends on lorenz_pkg and lorenz_alu.
//
//   channel   signals                          moves
//   in        in_valid / in_ready / in_data    one request per transfer
//   out       out_valid / out_ready / out_data one result per Euler step
//   config    wr_en / wr_index / wr_data       register write, no wait
//
// Each Euler step runs PREP, COEF, XY, NEWX, TY, TZ, NEWY, NEWZ: seven
// products pass in turn through the one shared multiplier, whose registered
// product is rescaled and summed in the following cycle. Batch steps run back
// to back; load and restore finish in idle. The input is ready only when idle.
// The output register lets the next step run while a result waits; a step
// holds in its final cycle while the output is full and not being taken.
// Reset restores the registers, the coordinates (0.1, 0, 0) and the counter.
module lorenz_attractor_euler_step_core #(
    parameter int MAX_BATCH = 64,
    parameter int FRAC_BITS = 22
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lorenz_pkg::req_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lorenz_pkg::res_t  out_data,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [31:0]       wr_data
);

    localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] SIGMA_Q = 64'd10 * ONE_Q;
    localparam logic [63:0] RHO_Q   = 64'd28 * ONE_Q;
    localparam logic [63:0] BETA_Q  = (64'd8 * ONE_Q + 64'd1) / 64'd3;
    localparam logic [63:0] H_Q     = (ONE_Q + 64'd50) / 64'd100;
    localparam logic [63:0] X_Q     = (ONE_Q + 64'd5) / 64'd10;
    localparam logic [63:0] Q_MAX   = 64'h0000_0000_7FFF_FFFF;

    localparam logic [31:0] SIGMA_INIT = (SIGMA_Q > Q_MAX) ? Q_MAX[31:0] : SIGMA_Q[31:0];
    localparam logic [31:0] RHO_INIT   = (RHO_Q > Q_MAX) ? Q_MAX[31:0] : RHO_Q[31:0];
    localparam logic [31:0] BETA_INIT  = (BETA_Q > Q_MAX) ? Q_MAX[31:0] : BETA_Q[31:0];
    localparam logic [22:0] H_INIT     = H_Q[22:0];
    localparam logic [31:0] X_INIT     = X_Q[31:0];
    localparam logic [6:0]  BATCH_CAP  = 7'(MAX_BATCH);

    lorenz_pkg::state_t state_reg, state_next;

    logic signed [31:0] sigma_reg, rho_reg, beta_reg;
    logic [22:0]        h_reg;
    logic [15:0]        warm_reg;

    logic signed [31:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [31:0]        cnt_reg, cnt_next;
    logic signed [31:0] ra_reg, ra_next, rb_reg, rb_next, rc_reg, rc_next, rd_reg, rd_next;
    logic [6:0]         rem_reg, rem_next;
    logic [5:0]         idx_reg, idx_next;
    logic               batch_reg, batch_next;
    logic               out_valid_reg, out_valid_next;
    lorenz_pkg::res_t   out_reg, out_next;
    logic               out_load;

    lorenz_pkg::alu_op_t op;
    logic signed [31:0] mul_a, mul_b, add_a, add_b, fm, sum, h_ext;
    logic [6:0]         batch_len;

    assign h_ext     = {9'd0, h_reg};
    assign in_ready  = (state_reg == lorenz_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign batch_len = (in_data.batch_count > BATCH_CAP) ? BATCH_CAP : in_data.batch_count;

    lorenz_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .op    (op),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .add_a (add_a),
        .add_b (add_b),
        .fm    (fm),
        .sum   (sum)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_INIT;
            rho_reg   <= RHO_INIT;
            beta_reg  <= BETA_INIT;
            h_reg     <= H_INIT;
            warm_reg  <= lorenz_pkg::WARMUP_INIT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                lorenz_pkg::REG_SIGMA:  sigma_reg <= wr_data;
                lorenz_pkg::REG_RHO:    rho_reg   <= wr_data;
                lorenz_pkg::REG_BETA:   beta_reg  <= wr_data;
                lorenz_pkg::REG_STEP_H: h_reg     <= wr_data[22:0];
                lorenz_pkg::REG_WARMUP: warm_reg  <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lorenz_pkg::ST_IDLE;
            x_reg         <= X_INIT;
            y_reg         <= '0;
            z_reg         <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            batch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            batch_reg     <= batch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        rc_reg  <= rc_next;
        rd_reg  <= rd_next;
        out_reg <= out_next;
    end

    // Sequencer: operand selection per cycle of the step schedule
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        cnt_next       = cnt_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rc_next        = rc_reg;
        rd_next        = rd_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        batch_next     = batch_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;
        op             = '0;
        mul_a          = '0;
        mul_b          = '0;
        add_a          = '0;
        add_b          = '0;

        unique case (state_reg)
            lorenz_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.req_type)
                        lorenz_pkg::REQ_STEP:
                        begin
                            rem_next   = 7'd1;
                            idx_next   = '0;
                            batch_next = 1'b0;
                            state_next = lorenz_pkg::ST_PREP;
                        end
                        lorenz_pkg::REQ_BATCH:
                        begin
                            rem_next   = batch_len;
                            idx_next   = '0;
                            batch_next = 1'b1;
                            if (batch_len != 7'd0)
                            begin
                                state_next = lorenz_pkg::ST_PREP;
                            end
                        end
                        lorenz_pkg::REQ_LOAD:
                        begin
                            x_next = in_data.load_x;
                            y_next = in_data.load_y;
                            z_next = in_data.load_z;
                        end
                        lorenz_pkg::REQ_RESTORE:
                        begin
                            x_next   = X_INIT;
                            y_next   = '0;
                            z_next   = '0;
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            lorenz_pkg::ST_PREP:
            begin
                op.mul_en  = 1'b1;
                mul_a      = h_ext;
                mul_b      = sigma_reg;
                op.sub     = 1'b1;
                add_a      = y_reg;
                add_b      = x_reg;
                ra_next    = sum;
                state_next = lorenz_pkg::ST_COEF;
            end
            lorenz_pkg::ST_COEF:
            begin
                op.mul_en  = 1'b1;
                mul_a      = x_reg;
                mul_b      = y_reg;
                rb_next    = fm;
                op.sub     = 1'b1;
                add_a      = rho_reg;
                add_b      = z_reg;
                rc_next    = sum;
                state_next = lorenz_pkg::ST_XY;
            end
            lorenz_pkg::ST_XY:
            begin
                op.mul_en  = 1'b1;
                mul_a      = rb_reg;
                mul_b      = ra_reg;
                rd_next    = fm;
                state_next = lorenz_pkg::ST_NEWX;
            end
            lorenz_pkg::ST_NEWX:
            begin
                op.mul_en  = 1'b1;
                mul_a      = x_reg;
                mul_b      = rc_reg;
                add_a      = x_reg;
                add_b      = fm;
                ra_next    = sum;
                state_next = lorenz_pkg::ST_TY;
            end
            lorenz_pkg::ST_TY:
            begin
                op.mul_en  = 1'b1;
                mul_a      = beta_reg;
                mul_b      = z_reg;
                op.sub     = 1'b1;
                add_a      = fm;
                add_b      = y_reg;
                rb_next    = sum;
                state_next = lorenz_pkg::ST_TZ;
            end
            lorenz_pkg::ST_TZ:
            begin
                op.mul_en  = 1'b1;
                mul_a      = h_ext;
                mul_b      = rb_reg;
                op.sub     = 1'b1;
                add_a      = rd_reg;
                add_b      = fm;
                rc_next    = sum;
                state_next = lorenz_pkg::ST_NEWY;
            end
            lorenz_pkg::ST_NEWY:
            begin
                op.mul_en  = 1'b1;
                mul_a      = h_ext;
                mul_b      = rc_reg;
                add_a      = y_reg;
                add_b      = fm;
                rb_next    = sum;
                state_next = lorenz_pkg::ST_NEWZ;
            end
            lorenz_pkg::ST_NEWZ:
            begin
                add_a    = z_reg;
                add_b    = fm;
                // Hold here until the output register is free or being taken
                out_load = !out_valid_reg || out_ready;
                if (out_load)
                begin
                    x_next                = ra_reg;
                    y_next                = rb_reg;
                    z_next                = sum;
                    out_next.pos_x        = ra_reg;
                    out_next.pos_y        = rb_reg;
                    out_next.pos_z        = sum;
                    out_next.coords_valid = cnt_reg > {16'd0, warm_reg};
                    out_next.step_number  = cnt_reg;
                    out_next.from_batch   = batch_reg;
                    out_next.batch_index  = idx_reg;
                    out_next.last         = (rem_reg == 7'd1);
                    out_valid_next        = 1'b1;
                    if (cnt_reg != 32'hFFFF_FFFF)
                    begin
                        cnt_next = cnt_reg + 32'd1;
                    end
                    rem_next = rem_reg - 7'd1;
                    idx_next = idx_reg + 6'd1;
                    state_next = (rem_reg == 7'd1) ? lorenz_pkg::ST_IDLE : lorenz_pkg::ST_PREP;
                end
            end
            default:
            begin
                state_next = lorenz_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lorenz_chk.sv =====
// Port-level checks for the Lorenz Euler-step core, bound to the top level.
// Depends on lorenz_pkg.
module lorenz_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input lorenz_pkg::req_t in_data,
    input logic             out_valid,
    input logic             out_ready,
    input lorenz_pkg::res_t out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // A transfer that starts stepping leaves the input busy
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == lorenz_pkg::REQ_STEP ||
        (in_data.req_type == lorenz_pkg::REQ_BATCH && in_data.batch_count != 7'd0))
        |=> !in_ready)
        else $error("input ready while a step is running");

    // Load and restore finish at once
    a_quick_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == lorenz_pkg::REQ_LOAD ||
        in_data.req_type == lorenz_pkg::REQ_RESTORE) |=> in_ready)
        else $error("input busy after load or restore");

    // A single step is always the last and first of its request
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.from_batch |-> out_data.last && out_data.batch_index == 6'd0)
        else $error("single step result with batch tagging");

endmodule

bind lorenz_attractor_euler_step_core lorenz_chk u_chk (.*);

// ===== bench/tb_lorenz_attractor_euler_step_core.sv =====
// Self-checking bench for lorenz_attractor_euler_step_core: requests, results and
// register writes are checked against an in-bench fixed-point Euler predictor.
// Depends on lorenz_pkg and the core, which in turn needs lorenz_alu.
module tb_lorenz_attractor_euler_step_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BATCH     = 64;
    localparam int FRAC_BITS     = 22;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;

    localparam logic signed [31:0] COORD_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [31:0] COORD_MIN   = 32'sh80000000;
    localparam logic signed [31:0] SIGMA_INIT  = 32'sd41943040;
    localparam logic signed [31:0] RHO_INIT    = 32'sd117440512;
    localparam logic signed [31:0] BETA_INIT   = 32'sd11184811;
    localparam logic [22:0]        STEP_H_INIT = 23'd41943;
    localparam logic signed [31:0] X_INIT      = 32'sd419430;
    localparam logic signed [31:0] ONE_FX      = 32'sd4194304;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    lorenz_pkg::req_t    in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    lorenz_pkg::res_t    out_data;
    logic                wr_en = 1'b0;
    logic [2:0]          wr_index = '0;
    logic [31:0]         wr_data = '0;

    // Predictor copy of registers and attractor state
    logic signed [31:0] cfg_sigma;
    logic signed [31:0] cfg_rho;
    logic signed [31:0] cfg_beta;
    logic [22:0]        cfg_step_h;
    logic [15:0]        cfg_warmup;
    logic signed [31:0] lz_x;
    logic signed [31:0] lz_y;
    logic signed [31:0] lz_z;
    logic [31:0]        lz_count;

    lorenz_pkg::req_t request_queue[$];
    lorenz_pkg::res_t expected_steps[$];
    lorenz_pkg::res_t step_due;

    bit idle_enabled = 1'b1;
    int fail_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int drain_wait;

    lorenz_attractor_euler_step_core #(
        .MAX_BATCH(MAX_BATCH),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return v[31:0];
    endfunction

    // Full product, floor shift, then clamp
    function automatic logic signed [31:0] fxmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clamp32(prod >>> FRAC_BITS);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_enabled)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic restore_coords();
        lz_x = X_INIT;
        lz_y = '0;
        lz_z = '0;
        lz_count = '0;
    endtask

    task automatic advance_lorenz(input logic batch, input logic [5:0] idx,
                                  input logic is_last);
        logic signed [31:0] x, y, z, hh, dx, ty, tz;
        lorenz_pkg::res_t r;
        x = lz_x;
        y = lz_y;
        z = lz_z;
        hh = $signed({9'd0, cfg_step_h});
        dx = fxmul(fxmul(hh, cfg_sigma), clamp32(longint'(y) - longint'(x)));
        ty = clamp32(longint'(fxmul(x, clamp32(longint'(cfg_rho) - longint'(z))))
                     - longint'(y));
        tz = clamp32(longint'(fxmul(x, y)) - longint'(fxmul(cfg_beta, z)));
        lz_x = clamp32(longint'(x) + longint'(dx));
        lz_y = clamp32(longint'(y) + longint'(fxmul(hh, ty)));
        lz_z = clamp32(longint'(z) + longint'(fxmul(hh, tz)));
        r.pos_x = lz_x;
        r.pos_y = lz_y;
        r.pos_z = lz_z;
        r.coords_valid = (lz_count > {16'd0, cfg_warmup});
        r.step_number = lz_count;
        r.from_batch = batch;
        r.batch_index = idx;
        r.last = is_last;
        expected_steps.push_back(r);
        // counter sticks at all ones
        if (lz_count != 32'hFFFFFFFF)
            lz_count++;
    endtask

    task automatic predict_request(input lorenz_pkg::req_t rq);
        int cnt;
        case (lorenz_pkg::req_kind_t'(rq.req_type))
            lorenz_pkg::REQ_STEP:
                advance_lorenz(1'b0, 6'd0, 1'b1);
            lorenz_pkg::REQ_BATCH:
            begin
                cnt = (rq.batch_count > MAX_BATCH) ? MAX_BATCH : int'(rq.batch_count);
                for (int i = 0; i < cnt; i++)
                    advance_lorenz(1'b1, 6'(i), i == cnt - 1);
            end
            lorenz_pkg::REQ_LOAD:
            begin
                lz_x = rq.load_x;
                lz_y = rq.load_y;
                lz_z = rq.load_z;
            end
            default:
                restore_coords();
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: predict on each transfer, then offer the next queued request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_request(in_data);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    in_data <= request_queue.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each transfer with the oldest expected step
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("unexpected result: 0x%h", out_data);
                    fail_count++;
                end
                else
                begin
                    step_due = expected_steps.pop_front();
                    check_field("pos_x", step_due.pos_x, out_data.pos_x);
                    check_field("pos_y", step_due.pos_y, out_data.pos_y);
                    check_field("pos_z", step_due.pos_z, out_data.pos_z);
                    check_field("coords_valid", 32'(step_due.coords_valid),
                                32'(out_data.coords_valid));
                    check_field("step_number", step_due.step_number,
                                out_data.step_number);
                    check_field("from_batch", 32'(step_due.from_batch),
                                32'(out_data.from_batch));
                    check_field("batch_index", 32'(step_due.batch_index),
                                32'(out_data.batch_index));
                    check_field("last", 32'(step_due.last), 32'(out_data.last));
                end
                results_seen++;
                // hold off long enough to back the core up into its input
                if (results_seen == 20 || results_seen == 300)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    function automatic lorenz_pkg::req_t make_req(input lorenz_pkg::req_kind_t kind,
                                                  input int count,
                                                  input logic signed [31:0] lx,
                                                  input logic signed [31:0] ly,
                                                  input logic signed [31:0] lz);
        lorenz_pkg::req_t rq;
        rq.req_type = kind;
        rq.batch_count = 7'(count);
        rq.load_x = lx;
        rq.load_y = ly;
        rq.load_z = lz;
        return rq;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        int r;
        logic [31:0] v;
        r = $urandom_range(99);
        if (r < 55)
        begin
            // within the usual orbit, about +/-40
            v = $urandom_range(0, 335544320);
            return v - 32'd167772160;
        end
        if (r < 80)
            return $urandom();
        if (r < 90)
        begin
            case ($urandom_range(3))
                0: return COORD_MAX;
                1: return COORD_MIN;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        v = $urandom_range(0, 8388607);
        return v - ONE_FX;
    endfunction

    function automatic int rand_batch();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 75)
            return $urandom_range(1, 6);
        if (r < 88)
            return $urandom_range(7, 20);
        if (r < 94)
            return MAX_BATCH;
        return $urandom_range(MAX_BATCH + 1, 127);
    endfunction

    function automatic lorenz_pkg::req_t random_req();
        lorenz_pkg::req_t rq;
        int r;
        r = $urandom_range(99);
        rq.load_x = rand_coord();
        rq.load_y = rand_coord();
        rq.load_z = rand_coord();
        rq.batch_count = 7'($urandom());
        if (r < 45)
            rq.req_type = lorenz_pkg::REQ_STEP;
        else if (r < 75)
        begin
            rq.req_type = lorenz_pkg::REQ_BATCH;
            rq.batch_count = 7'(rand_batch());
        end
        else if (r < 90)
            rq.req_type = lorenz_pkg::REQ_LOAD;
        else
            rq.req_type = lorenz_pkg::REQ_RESTORE;
        return rq;
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            request_queue.push_back(random_req());
    endtask

    // Wait for every request and step to clear, then let load/restore settle
    task automatic wait_idle();
        while (request_queue.size() != 0 || in_valid || expected_steps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        case (idx)
            lorenz_pkg::REG_SIGMA:  cfg_sigma = data;
            lorenz_pkg::REG_RHO:    cfg_rho = data;
            lorenz_pkg::REG_BETA:   cfg_beta = data;
            lorenz_pkg::REG_STEP_H: cfg_step_h = data[22:0];
            lorenz_pkg::REG_WARMUP: cfg_warmup = data[15:0];
            default:    ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Junk in the unused upper bits must be dropped
    task automatic set_registers(input logic [31:0] s, input logic [31:0] r,
                                 input logic [31:0] b, input logic [22:0] h,
                                 input logic [15:0] w);
        logic [31:0] hw, ww;
        hw = $urandom();
        hw[22:0] = h;
        ww = $urandom();
        ww[15:0] = w;
        write_reg(lorenz_pkg::REG_SIGMA, s);
        write_reg(lorenz_pkg::REG_RHO, r);
        write_reg(lorenz_pkg::REG_BETA, b);
        write_reg(lorenz_pkg::REG_STEP_H, hw);
        write_reg(lorenz_pkg::REG_WARMUP, ww);
        end_writes();
    endtask

    initial
    begin
        cfg_sigma = SIGMA_INIT;
        cfg_rho = RHO_INIT;
        cfg_beta = BETA_INIT;
        cfg_step_h = STEP_H_INIT;
        cfg_warmup = lorenz_pkg::WARMUP_INIT;
        restore_coords();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset defaults, batch edges, warm-up crossing, extreme loads
        request_queue.push_back(make_req(lorenz_pkg::REQ_STEP, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_STEP, 127, COORD_MAX,
                                         COORD_MIN, -1));
        request_queue.push_back(make_req(lorenz_pkg::REQ_BATCH, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_BATCH, 1, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_BATCH, MAX_BATCH, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_BATCH, 100, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_STEP, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_LOAD, 0, COORD_MAX,
                                         COORD_MAX, COORD_MAX));
        request_queue.push_back(make_req(lorenz_pkg::REQ_STEP, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_LOAD, 0, COORD_MIN,
                                         COORD_MIN, COORD_MIN));
        request_queue.push_back(make_req(lorenz_pkg::REQ_STEP, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_LOAD, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_STEP, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_LOAD, 0, COORD_MAX,
                                         COORD_MIN, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_BATCH, 3, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_RESTORE, 0, COORD_MAX,
                                         COORD_MAX, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_STEP, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_BATCH, 127, COORD_MIN,
                                         COORD_MAX, -1));
        request_queue.push_back(make_req(lorenz_pkg::REQ_LOAD, 0, -ONE_FX, ONE_FX,
                                         -ONE_FX));
        request_queue.push_back(make_req(lorenz_pkg::REQ_RESTORE, 0, 0, 0, 0));
        request_queue.push_back(make_req(lorenz_pkg::REQ_BATCH, 2, 0, 0, 0));
        wait_idle();

        // Defaults, random traffic
        queue_random(20);
        wait_idle();

        // Coefficients near the classic values
        set_registers($urandom_range(0, 67108864), $urandom_range(0, 167772160),
                      $urandom_range(0, 16777216), 23'($urandom_range(0, 83886)),
                      16'($urandom_range(0, 300)));
        queue_random(15);
        wait_idle();

        // Sigma and beta at the positive extreme, rho at the negative, unit step, no warm-up
        set_registers(COORD_MAX, COORD_MIN, COORD_MAX, 23'(ONE_FX), 16'd0);
        queue_random(15);
        wait_idle();

        // Sigma and beta at the negative extreme, rho at the positive, zero step, longest warm-up
        set_registers(COORD_MIN, COORD_MAX, COORD_MIN, 23'd0, 16'hFFFF);
        queue_random(15);
        wait_idle();

        // Fully random registers; unmapped indexes must be ignored
        for (int k = int'(lorenz_pkg::REG_WARMUP) + 1; k < 8; k++)
            write_reg(3'(k), $urandom());
        set_registers($urandom(), $urandom(), $urandom(),
                      23'($urandom_range(0, 4194304)), 16'($urandom()));
        queue_random(30);
        wait_idle();

        // Back to defaults, back-to-back with no idling
        set_registers(SIGMA_INIT, RHO_INIT, BETA_INIT, STEP_H_INIT,
                      lorenz_pkg::WARMUP_INIT);
        idle_enabled = 1'b0;
        request_queue.push_back(make_req(lorenz_pkg::REQ_RESTORE, 0, 0, 0, 0));
        queue_random(40);

        while (request_queue.size() != 0 || in_valid)
            @(negedge clk);
        drain_wait = 0;
        while (expected_steps.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_wait++;
        end
        if (expected_steps.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_steps.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
